### rtl/core/cdll_pkg.sv
package cdll_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int OP_W     = 3;
   localparam int POS_W    = 8;
   localparam int STS_W    = 2;
   localparam int LEN_W    = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_INS_POS  = 3'd2,
      OP_DEL_HEAD = 3'd3,
      OP_DEL_TAIL = 3'd4,
      OP_DEL_POS  = 3'd5,
      OP_DUMP_FWD = 3'd6,
      OP_DUMP_REV = 3'd7
   } opcode_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK     = 2'd0,
      STS_BADPOS = 2'd1,
      STS_FULL   = 2'd2,
      STS_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_INS_LINK,
      ST_INS_JOIN,
      ST_DUMP
   } state_type;

   typedef enum logic [1:0] {
      INS_AT_HEAD,
      INS_AT_TAIL,
      INS_IN_MID
   } ins_mode_type;

   function automatic logic [IDX_W-1:0] lowest_free(input logic [CAPACITY-1:0] map);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (map[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

### rtl/core/cdll_ram.sv
module cdll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/circular_doubly_linked_list_manager_core.sv
// circular doubly linked list of signed 32-bit values in a pool of nodes
// request channel: drive req_opcode, req_value, req_position with start high;
// the request is taken at a clock edge where start is high and busy is low
// result channel: each result shows for one cycle with rsp_valid high, and
// rsp_last marks the final result of a request; results are never held off
// value, next link and prev link live in three one-port-write RAMs with a
// registered read; links are followed one node per cycle
// steps from acceptance until busy falls:
//   rejected (bad position, full, empty): busy stays low, next request at once
//   insert at head or tail: write the new node, then link its neighbours
//   insert at position p in the middle: walk to node p - 1, then as above
//   delete head or tail: unlink it; delete at position p: walk to it, unlink
//   dump of n elements: walk the list, one result per cycle
// each result is registered and shows in the cycle after the one that made it
// the worst case is set by the link walk
// reset empties the list and frees every node; no clearing pass is needed
module circular_doubly_linked_list_manager_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cdll_pkg::OP_W-1:0]           req_opcode,
   input  logic signed [cdll_pkg::VAL_W-1:0]   req_value,
   input  logic [cdll_pkg::POS_W-1:0]          req_position,
   output logic                                rsp_valid,
   output logic signed [cdll_pkg::VAL_W-1:0]   rsp_element,
   output logic [cdll_pkg::STS_W-1:0]          rsp_status,
   output logic [cdll_pkg::LEN_W-1:0]          rsp_length,
   output logic                                rsp_last
);

   localparam int IDX_W = cdll_pkg::IDX_W;
   localparam int CNT_W = cdll_pkg::CNT_W;
   localparam int VAL_W = cdll_pkg::VAL_W;
   localparam int POS_W = cdll_pkg::POS_W;
   localparam int LEN_W = cdll_pkg::LEN_W;
   localparam int CAP   = cdll_pkg::CAPACITY;

   cdll_pkg::state_type    state_ff, state_in;
   cdll_pkg::ins_mode_type mode_ff, mode_in;

   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] steps_ff, steps_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             fwd_ff, fwd_in;
   logic             is_del_ff, is_del_in;
   logic [IDX_W-1:0] new_ff, new_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0] before_ff, before_in;
   logic [IDX_W-1:0] after_ff, after_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CAP-1:0]   free_ff, free_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]         rsp_element_ff, rsp_element_in;
   cdll_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]                rsp_length_ff, rsp_length_in;
   logic                            rsp_last_ff, rsp_last_in;

   // ram ports
   logic             val_we, nxt_we, prv_we;
   logic [IDX_W-1:0] val_wa, nxt_wa, prv_wa;
   logic [VAL_W-1:0] val_wd, val_rd;
   logic [IDX_W-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd;

   // request decode
   cdll_pkg::opcode_type op;
   cdll_pkg::status_type req_sts;
   logic             accept;
   logic             req_err;
   logic             empty, full;
   logic [POS_W:0]   pos_x, cnt_x;
   logic             ins_mid, ins_head;

   assign accept = start && (state_ff == cdll_pkg::ST_IDLE);
   assign busy   = (state_ff != cdll_pkg::ST_IDLE);
   assign op     = cdll_pkg::opcode_type'(req_opcode);
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CNT_W'(CAP));
   assign pos_x  = {1'b0, req_position};
   assign cnt_x  = (POS_W + 1)'(count_ff);

   assign ins_head = (op == cdll_pkg::OP_INS_HEAD) ||
                     ((op == cdll_pkg::OP_INS_POS) && (pos_x == 9'd1));
   assign ins_mid  = (op == cdll_pkg::OP_INS_POS) && (pos_x != 9'd1) &&
                     (pos_x != cnt_x + 9'd1);

   always_comb begin
      req_err = 1'b0;
      req_sts = cdll_pkg::STS_OK;
      unique case (op)
         cdll_pkg::OP_INS_HEAD, cdll_pkg::OP_INS_TAIL: begin
            if (full) begin
               req_err = 1'b1;
               req_sts = cdll_pkg::STS_FULL;
            end
         end
         cdll_pkg::OP_INS_POS: begin
            priority if ((pos_x == '0) || (pos_x > cnt_x + 9'd1)) begin
               req_err = 1'b1;
               req_sts = cdll_pkg::STS_BADPOS;
            end else if (full) begin
               req_err = 1'b1;
               req_sts = cdll_pkg::STS_FULL;
            end else begin
               req_err = 1'b0;
            end
         end
         cdll_pkg::OP_DEL_POS: begin
            priority if (empty) begin
               req_err = 1'b1;
               req_sts = cdll_pkg::STS_EMPTY;
            end else if ((pos_x == '0) || (pos_x > cnt_x)) begin
               req_err = 1'b1;
               req_sts = cdll_pkg::STS_BADPOS;
            end else begin
               req_err = 1'b0;
            end
         end
         default: begin
            if (empty) begin
               req_err = 1'b1;
               req_sts = cdll_pkg::STS_EMPTY;
            end
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cdll_pkg::ST_IDLE: begin
            if (accept && !req_err) begin
               unique case (op)
                  cdll_pkg::OP_INS_HEAD, cdll_pkg::OP_INS_TAIL, cdll_pkg::OP_INS_POS: begin
                     state_in = ins_mid ? cdll_pkg::ST_WALK : cdll_pkg::ST_INS_LINK;
                  end
                  cdll_pkg::OP_DEL_HEAD, cdll_pkg::OP_DEL_TAIL, cdll_pkg::OP_DEL_POS: begin
                     state_in = cdll_pkg::ST_WALK;
                  end
                  default: begin
                     state_in = cdll_pkg::ST_DUMP;
                  end
               endcase
            end
         end
         cdll_pkg::ST_WALK: begin
            if (steps_ff == '0) begin
               state_in = is_del_ff ? cdll_pkg::ST_IDLE : cdll_pkg::ST_INS_LINK;
            end
         end
         cdll_pkg::ST_INS_LINK: state_in = cdll_pkg::ST_INS_JOIN;
         cdll_pkg::ST_INS_JOIN: state_in = cdll_pkg::ST_IDLE;
         cdll_pkg::ST_DUMP: begin
            if (left_ff == CNT_W'(1)) begin
               state_in = cdll_pkg::ST_IDLE;
            end
         end
         default: state_in = cdll_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cur_in    = cur_ff;
      steps_in  = steps_ff;
      left_in   = left_ff;
      fwd_in    = fwd_ff;
      is_del_in = is_del_ff;
      mode_in   = mode_ff;
      new_in    = new_ff;
      value_in  = value_ff;
      before_in = before_ff;
      after_in  = after_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      free_in   = free_ff;

      rsp_valid_in   = 1'b0;
      rsp_element_in = '0;
      rsp_status_in  = cdll_pkg::STS_OK;
      rsp_length_in  = LEN_W'(count_ff);
      rsp_last_in    = 1'b1;

      val_we = 1'b0;
      val_wa = new_ff;
      val_wd = value_ff;
      nxt_we = 1'b0;
      nxt_wa = new_ff;
      nxt_wd = after_ff;
      prv_we = 1'b0;
      prv_wa = new_ff;
      prv_wd = before_ff;

      unique case (state_ff)
         cdll_pkg::ST_IDLE: begin
            if (accept) begin
               value_in  = req_value;
               new_in    = cdll_pkg::lowest_free(free_ff);
               is_del_in = (op == cdll_pkg::OP_DEL_HEAD) || (op == cdll_pkg::OP_DEL_TAIL) ||
                           (op == cdll_pkg::OP_DEL_POS);
               fwd_in    = (op != cdll_pkg::OP_DUMP_REV);
               cur_in    = ((op == cdll_pkg::OP_DEL_TAIL) || (op == cdll_pkg::OP_DUMP_REV)) ?
                           tail_ff : head_ff;
               left_in   = count_ff;
               priority if (ins_mid) begin
                  mode_in = cdll_pkg::INS_IN_MID;
               end else if (ins_head) begin
                  mode_in = cdll_pkg::INS_AT_HEAD;
               end else begin
                  mode_in = cdll_pkg::INS_AT_TAIL;
               end
               priority if (op == cdll_pkg::OP_DEL_POS) begin
                  steps_in = IDX_W'(req_position - 8'd1);
               end else if (op == cdll_pkg::OP_INS_POS) begin
                  steps_in = IDX_W'(req_position - 8'd2);
               end else begin
                  steps_in = '0;
               end
               before_in = empty ? cdll_pkg::lowest_free(free_ff) : tail_ff;
               after_in  = empty ? cdll_pkg::lowest_free(free_ff) : head_ff;
               if (req_err) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = req_sts;
               end
            end
         end
         cdll_pkg::ST_WALK: begin
            if (steps_ff == '0) begin
               if (is_del_ff) begin
                  // unlink cur_ff using its own links
                  count_in         = count_ff - CNT_W'(1);
                  free_in[cur_ff]  = 1'b1;
                  if (count_ff == CNT_W'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     nxt_we = 1'b1;
                     nxt_wa = prv_rd;
                     nxt_wd = nxt_rd;
                     prv_we = 1'b1;
                     prv_wa = nxt_rd;
                     prv_wd = prv_rd;
                     if (cur_ff == head_ff) begin
                        head_in = nxt_rd;
                     end
                     if (cur_ff == tail_ff) begin
                        tail_in = prv_rd;
                     end
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_length_in = LEN_W'(count_in);
               end else begin
                  before_in = cur_ff;
                  after_in  = nxt_rd;
               end
            end else begin
               cur_in   = nxt_rd;
               steps_in = steps_ff - IDX_W'(1);
            end
         end
         cdll_pkg::ST_INS_LINK: begin
            val_we = 1'b1;
            nxt_we = 1'b1;
            prv_we = 1'b1;
         end
         cdll_pkg::ST_INS_JOIN: begin
            prv_we = 1'b1;
            prv_wa = after_ff;
            prv_wd = new_ff;
            nxt_we = 1'b1;
            nxt_wa = before_ff;
            nxt_wd = new_ff;
            free_in[new_ff] = 1'b0;
            count_in        = count_ff + CNT_W'(1);
            if ((mode_ff == cdll_pkg::INS_AT_HEAD) || empty) begin
               head_in = new_ff;
            end
            if ((mode_ff == cdll_pkg::INS_AT_TAIL) || empty) begin
               tail_in = new_ff;
            end
            rsp_valid_in  = 1'b1;
            rsp_length_in = LEN_W'(count_in);
         end
         cdll_pkg::ST_DUMP: begin
            rsp_valid_in   = 1'b1;
            rsp_element_in = val_rd;
            rsp_last_in    = (left_ff == CNT_W'(1));
            cur_in         = fwd_ff ? nxt_rd : prv_rd;
            left_in        = left_ff - CNT_W'(1);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdll_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      steps_ff       <= steps_in;
      left_ff        <= left_in;
      fwd_ff         <= fwd_in;
      is_del_ff      <= is_del_in;
      mode_ff        <= mode_in;
      new_ff         <= new_in;
      value_ff       <= value_in;
      before_ff      <= before_in;
      after_ff       <= after_in;
      rsp_element_ff <= rsp_element_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_length  = rsp_length_ff;
   assign rsp_last    = rsp_last_ff;

   // read address follows cur_in so read data always belongs to cur_ff
   cdll_ram #(.WIDTH(VAL_W), .DEPTH(CAP)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_addr (cur_in),
      .rd_data (val_rd)
   );

   cdll_ram #(.WIDTH(IDX_W), .DEPTH(CAP)) u_nxt_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_addr (cur_in),
      .rd_data (nxt_rd)
   );

   cdll_ram #(.WIDTH(IDX_W), .DEPTH(CAP)) u_prv_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_wa),
      .wr_data (prv_wd),
      .rd_addr (cur_in),
      .rd_data (prv_rd)
   );

   a_free_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(~free_ff) == int'(count_ff))
      else $error("free map disagrees with element count");

   a_empty_clears_ends: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> ((head_ff == '0) && (tail_ff == '0)))
      else $error("empty list with nonzero head or tail");

   a_last_ends_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == cdll_pkg::ST_IDLE))
      else $error("final result while request still in progress");

   a_quiet_while_linking: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == cdll_pkg::ST_WALK) || (state_ff == cdll_pkg::ST_INS_LINK) ||
       (state_ff == cdll_pkg::ST_INS_JOIN)) |-> !rsp_valid_ff)
      else $error("result emitted during link update");

endmodule

### tb/circular_doubly_linked_list_manager_core_checker.sv
module circular_doubly_linked_list_manager_core_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [cdll_pkg::OP_W-1:0]           req_opcode,
   input  logic signed [cdll_pkg::VAL_W-1:0]   req_value,
   input  logic [cdll_pkg::POS_W-1:0]          req_position,
   input  logic                                rsp_valid,
   input  logic signed [cdll_pkg::VAL_W-1:0]   rsp_element,
   input  logic [cdll_pkg::STS_W-1:0]          rsp_status,
   input  logic [cdll_pkg::LEN_W-1:0]          rsp_length,
   input  logic                                rsp_last,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  results_seen
);
   import cdll_pkg::*;

   typedef struct packed {
      logic signed [VAL_W-1:0] element;
      status_type              status;
      logic [LEN_W-1:0]        length;
      logic                    last;
   } list_result_t;

   logic signed [VAL_W-1:0] list_contents[$];
   list_result_t            expected_results[$];
   int                      mismatch_count = 0;
   int                      result_count = 0;

   assign fail_count   = mismatch_count;
   assign results_seen = result_count;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic push_result(input logic signed [VAL_W-1:0] elem, input status_type sts,
                              input logic fin);
      list_result_t r;
      r.element = elem;
      r.status  = sts;
      r.length  = LEN_W'(list_contents.size());
      r.last    = fin;
      expected_results.push_back(r);
   endtask

   task automatic predict_list_op(input opcode_type op, input logic signed [VAL_W-1:0] v,
                                  input logic [POS_W-1:0] p);
      status_type sts;
      int         n;
      int         pos;
      sts = STS_OK;
      n   = list_contents.size();
      pos = int'(p);
      case (op)
         OP_INS_HEAD, OP_INS_TAIL: begin
            if (n >= CAPACITY)
               sts = STS_FULL;
            else if (op == OP_INS_HEAD)
               list_contents.push_front(v);
            else
               list_contents.push_back(v);
         end
         OP_INS_POS: begin
            if (pos < 1 || pos > n + 1)
               sts = STS_BADPOS;
            else if (n >= CAPACITY)
               sts = STS_FULL;
            else
               list_contents.insert(pos - 1, v);
         end
         OP_DEL_HEAD: begin
            if (n == 0)
               sts = STS_EMPTY;
            else
               void'(list_contents.pop_front());
         end
         OP_DEL_TAIL: begin
            if (n == 0)
               sts = STS_EMPTY;
            else
               void'(list_contents.pop_back());
         end
         OP_DEL_POS: begin
            if (n == 0)
               sts = STS_EMPTY;
            else if (pos < 1 || pos > n)
               sts = STS_BADPOS;
            else
               list_contents.delete(pos - 1);
         end
         default: begin
            if (n == 0) begin
               sts = STS_EMPTY;
            end else begin
               for (int k = 0; k < n; k++) begin
                  push_result(op == OP_DUMP_FWD ? list_contents[k] : list_contents[n - 1 - k],
                              STS_OK, k == n - 1);
               end
               return;
            end
         end
      endcase
      push_result('0, sts, 1'b1);
   endtask

   always @(posedge clock) begin
      list_result_t want;
      if (reset) begin
         list_contents.delete();
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result element", rsp_element, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_element !== want.element)
                  report_mismatch("element", rsp_element, want.element);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_length !== want.length)
                  report_mismatch("length", rsp_length, want.length);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         if (start && !busy)
            predict_list_op(opcode_type'(req_opcode), req_value, req_position);
      end
      pending <= expected_results.size();
   end

endmodule

### tb/circular_doubly_linked_list_manager_core_tb.sv
module circular_doubly_linked_list_manager_core_tb;
   import cdll_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [OP_W-1:0]         req_opcode = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic [POS_W-1:0]        req_position = '0;
   logic                    rsp_valid;
   logic signed [VAL_W-1:0] rsp_element;
   logic [STS_W-1:0]        rsp_status;
   logic [LEN_W-1:0]        rsp_length;
   logic                    rsp_last;
   int                      fail_count;
   int                      pending;
   int                      results_seen;
   int                      sender_idle_pct = 0;
   int                      requests_sent = 0;

   always #6 clock = ~clock;

   circular_doubly_linked_list_manager_core dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_element  (rsp_element),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length),
      .rsp_last     (rsp_last)
   );

   circular_doubly_linked_list_manager_core_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_element  (rsp_element),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length),
      .rsp_last     (rsp_last),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen)
   );

   task automatic issue_request(input opcode_type op, input logic signed [VAL_W-1:0] v,
                                input logic [POS_W-1:0] p);
      while ($urandom_range(99) < sender_idle_pct) begin
         start        <= 1'b0;
         req_opcode   <= OP_W'($urandom);
         req_value    <= $urandom;
         req_position <= POS_W'($urandom);
         @(posedge clock);
      end
      start        <= 1'b1;
      req_opcode   <= op;
      req_value    <= v;
      req_position <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
   endtask

   initial begin
      int         roll;
      int         mode;
      opcode_type op;
      logic [POS_W-1:0] pos;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corners
      issue_request(OP_DUMP_FWD, 32'sh0, 8'd0);
      issue_request(OP_DUMP_REV, 32'sh0, 8'd0);
      issue_request(OP_DEL_HEAD, 32'sh0, 8'd0);
      issue_request(OP_DEL_TAIL, 32'sh0, 8'd0);
      issue_request(OP_DEL_POS, 32'sh0, 8'd1);
      issue_request(OP_INS_POS, 32'sh11, 8'd0);
      issue_request(OP_INS_POS, 32'sh22, 8'd2);
      // build with extreme values and boundary positions
      issue_request(OP_INS_HEAD, 32'sh7fffffff, 8'd0);
      issue_request(OP_INS_TAIL, 32'sh80000000, 8'd255);
      issue_request(OP_INS_POS, -32'sd1, 8'd1);
      issue_request(OP_INS_POS, 32'sh0, 8'd4);
      issue_request(OP_INS_POS, 32'sh5a5a5a5a, 8'd3);
      issue_request(OP_INS_POS, 32'sh12345678, 8'd255);
      issue_request(OP_DUMP_FWD, 32'sh0, 8'd0);
      issue_request(OP_DUMP_REV, 32'sh0, 8'd0);
      // positional deletes at the edges and in the middle
      issue_request(OP_DEL_POS, 32'sh0, 8'd0);
      issue_request(OP_DEL_POS, 32'sh0, 8'd6);
      issue_request(OP_DEL_POS, 32'sh0, 8'd5);
      issue_request(OP_DEL_POS, 32'sh0, 8'd1);
      issue_request(OP_DEL_POS, 32'sh0, 8'd2);
      issue_request(OP_DEL_HEAD, 32'sh0, 8'd0);
      issue_request(OP_DEL_TAIL, 32'sh0, 8'd0);
      issue_request(OP_DUMP_FWD, 32'sh0, 8'd0);

      // random bursts: grow, grow, shrink, shrink, grow, mixed
      for (int i = 0; i < 96; i++) begin
         sender_idle_pct = (i < 32) ? 6 : (i < 64) ? 76 : 0;
         mode = (i / 16) % 6;
         roll = $urandom_range(99);
         if (mode == 0 || mode == 1 || mode == 4) begin
            if (roll < 50)
               op = $urandom_range(1) ? OP_INS_TAIL : OP_INS_HEAD;
            else if (roll < 85)
               op = OP_INS_POS;
            else if (roll < 93)
               op = $urandom_range(1) ? OP_DUMP_REV : OP_DUMP_FWD;
            else
               op = opcode_type'($urandom_range(OP_DEL_HEAD, OP_DEL_POS));
         end else if (mode == 2 || mode == 3) begin
            if (roll < 30)
               op = $urandom_range(1) ? OP_DEL_TAIL : OP_DEL_HEAD;
            else if (roll < 75)
               op = OP_DEL_POS;
            else if (roll < 85)
               op = $urandom_range(1) ? OP_DUMP_REV : OP_DUMP_FWD;
            else
               op = opcode_type'($urandom_range(OP_INS_HEAD, OP_INS_POS));
         end else begin
            op = opcode_type'($urandom_range(7));
         end
         if ($urandom_range(7) == 0)
            pos = POS_W'($urandom_range(255));
         else
            pos = POS_W'($urandom_range(18));
         issue_request(op, $urandom, pos);
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d requests driven, %0d results checked", requests_sent, results_seen);
      $display("covered empty, full and bad-position cases with sparse, heavy and no gaps");
      if (fail_count == 0)
         $display("circular_doubly_linked_list_manager_core_tb: clean");
      else
         $display("circular_doubly_linked_list_manager_core_tb: errors");
      $finish;
   end

   initial begin
      #3000000;
      $display("circular_doubly_linked_list_manager_core_tb: errors");
      $finish;
   end

endmodule
